@@ sv/jbcr_pkg.sv @@
// Shared types, constants and answer-encoding functions for the controller responder.
// Used by jbcr_front, jbcr_fifo, jbcr_back and joybus_controller_responder.
package jbcr_pkg;

	// Report bytes sent in answer to a status command (1 to 8)
	localparam int REPORT_BYTES = 8;

	// Command codes
	localparam logic [7:0] CMD_PROBE  = 8'h00;
	localparam logic [7:0] CMD_REPORT = 8'h40;
	localparam logic [7:0] CMD_ORIGIN = 8'h41;

	// Input kinds
	localparam logic KIND_RX_BYTE = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	// Result kinds
	localparam logic OUT_TX     = 1'b0;
	localparam logic OUT_RESYNC = 1'b1;

	// Stop symbol in a half word
	localparam logic [15:0] STOP_HALF = 16'h0003;

	// Job codes passed from front to back
	localparam logic [1:0] JOB_PROBE  = 2'd0;
	localparam logic [1:0] JOB_ORIGIN = 2'd1;
	localparam logic [1:0] JOB_REPORT = 2'd2;
	localparam logic [1:0] JOB_RESYNC = 2'd3;

	// Answer lengths in bytes and in words
	localparam int LEN_PROBE_I  = 3;
	localparam int LEN_ORIGIN_I = 10;
	localparam logic [3:0] LEN_PROBE  = 4'(LEN_PROBE_I);
	localparam logic [3:0] LEN_ORIGIN = 4'(LEN_ORIGIN_I);
	localparam logic [3:0] LEN_REPORT = 4'(REPORT_BYTES);
	localparam logic [2:0] WORDS_PROBE  = 3'(LEN_PROBE_I / 2 + 1);
	localparam logic [2:0] WORDS_ORIGIN = 3'(LEN_ORIGIN_I / 2 + 1);
	localparam logic [2:0] WORDS_REPORT = 3'(REPORT_BYTES / 2 + 1);

	// Origin centre value
	localparam logic [7:0] ORIGIN_CENTRE = 8'h7F;
	localparam logic [7:0] ORIGIN_MID    = 8'h80;

	// Job queue depth
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0]  code;
		logic [63:0] report;
	} job_t;

	// Byte idx of the answer for a given job
	function automatic logic [7:0] answer_byte(input logic [1:0] code,
			input logic [63:0] report, input logic [3:0] idx);
		logic [7:0] b;
		b = 8'h00;
		unique case (code)
			JOB_PROBE: begin
				case (idx)
					4'd0:    b = 8'h09;
					4'd1:    b = 8'h00;
					4'd2:    b = 8'h03;
					default: b = 8'h00;
				endcase
			end
			JOB_ORIGIN: begin
				case (idx) inside
					4'd1:          b = ORIGIN_MID;
					[4'd2:4'd5]:   b = ORIGIN_CENTRE;
					default:       b = 8'h00;
				endcase
			end
			JOB_REPORT: begin
				for (int k = 0; k < 8; k++) begin
					if (idx == 4'(k)) begin
						b = report[63 - 8 * k -: 8];
					end
				end
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [3:0] answer_len(input logic [1:0] code);
		logic [3:0] n;
		unique case (code)
			JOB_PROBE:  n = LEN_PROBE;
			JOB_ORIGIN: n = LEN_ORIGIN;
			JOB_REPORT: n = LEN_REPORT;
			default:    n = 4'd0;
		endcase
		return n;
	endfunction

	function automatic logic [2:0] answer_words(input logic [1:0] code);
		logic [2:0] n;
		unique case (code)
			JOB_PROBE:  n = WORDS_PROBE;
			JOB_ORIGIN: n = WORDS_ORIGIN;
			JOB_REPORT: n = WORDS_REPORT;
			default:    n = 3'd1;
		endcase
		return n;
	endfunction

	// Each bit, MSB first, becomes the pair 1 then data (data in the lower bit)
	function automatic logic [15:0] pair_encode(input logic [7:0] b);
		logic [15:0] h;
		for (int j = 0; j < 8; j++) begin
			h[2 * j + 1] = 1'b1;
			h[2 * j]     = b[7 - j];
		end
		return h;
	endfunction

	// Half word for answer byte position idx: data, stop symbol or empty
	function automatic logic [15:0] answer_half(input logic [1:0] code,
			input logic [63:0] report, input logic [3:0] idx);
		logic [3:0]  len;
		logic [15:0] h;
		len = answer_len(code);
		if (idx < len) begin
			h = pair_encode(answer_byte(code, report, idx));
		end else if (idx == len) begin
			h = STOP_HALF;
		end else begin
			h = 16'h0000;
		end
		return h;
	endfunction

endpackage

@@ sv/joybus_controller_responder.sv @@
// Controller responder top level: front classifier, job queue and answer encoder.
// Depends on jbcr_pkg, jbcr_front, jbcr_fifo and jbcr_back.
//
// Each request is a received line byte or a new 8-byte controller report. A
// probe command answers two words, an origin command six, a status command
// (after its two argument bytes) REPORT_BYTES/2+1 words, and an unknown command
// one resync result. The encoder loads each job from the two-entry queue and then
// sends one word per cycle while the output is not stalled; requests that give no
// result are taken every cycle while the queue has room.
module joybus_controller_responder import jbcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  rx_byte,
	input  logic [63:0] report_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        out_kind,
	output logic [31:0] tx_word,
	output logic        last_word
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	job_t push_job;
	job_t pop_job;

	// Classify requests
	jbcr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.rx_byte      (rx_byte),
		.report_value (report_value),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_job        (push_job)
	);

	// Queue jobs
	jbcr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_job  (pop_job)
	);

	// Encode answers
	jbcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_job     (pop_job),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_kind  (out_kind),
		.tx_word   (tx_word),
		.last_word (last_word)
	);

endmodule

@@ sv/jbcr_front.sv @@
// Front part of the controller responder: takes requests, keeps the report and
// argument count, and turns each command into a job. Depends on jbcr_pkg.
module jbcr_front import jbcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  rx_byte,
	input  logic [63:0] report_value,
	input  logic        q_full,
	output logic        q_push,
	output job_t        q_job
);

	logic [63:0] report_q;
	logic [1:0]  skip_q;
	logic        accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// Classify the request
	always_comb begin
		q_push      = 1'b0;
		q_job.code  = JOB_RESYNC;
		q_job.report = report_q;
		if (accept && kind == KIND_RX_BYTE) begin
			if (skip_q != 2'd0) begin
				if (skip_q == 2'd1) begin
					q_push     = 1'b1;
					q_job.code = JOB_REPORT;
				end
			end else begin
				unique case (rx_byte)
					CMD_PROBE: begin
						q_push     = 1'b1;
						q_job.code = JOB_PROBE;
					end
					CMD_ORIGIN: begin
						q_push     = 1'b1;
						q_job.code = JOB_ORIGIN;
					end
					CMD_REPORT: begin
						q_push = 1'b0;
					end
					default: begin
						q_push     = 1'b1;
						q_job.code = JOB_RESYNC;
					end
				endcase
			end
		end
	end

	// Hold the report and count down argument bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_q <= '0;
			skip_q   <= 2'd0;
		end else if (accept) begin
			if (kind == KIND_REPORT) begin
				report_q <= report_value;
			end else if (skip_q != 2'd0) begin
				skip_q <= skip_q - 2'd1;
			end else if (rx_byte == CMD_REPORT) begin
				skip_q <= 2'd2;
			end
		end
	end

endmodule

@@ sv/jbcr_fifo.sv @@
// Short job queue between front and back of the controller responder.
// Depends on jbcr_pkg for the job type and depth.
module jbcr_fifo import jbcr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t pop_job
);

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = slot_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	// Store incoming jobs
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

@@ sv/jbcr_back.sv @@
// Back part of the controller responder: takes jobs from the queue and sends the encoded
// answer one word per cycle if not stalled, via an output register. Depends on jbcr_pkg.
module jbcr_back import jbcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  job_t        q_job,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        out_kind,
	output logic [31:0] tx_word,
	output logic        last_word
);

	job_t        job_q;
	logic        busy_q;
	logic [2:0]  idx_q;
	logic        out_valid_q;
	logic        out_kind_q;
	logic [31:0] tx_word_q;
	logic        last_word_q;
	logic        adv;
	logic        last;
	logic [31:0] word;

	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = !busy_q && !q_empty;
	assign last  = (idx_q == answer_words(job_q.code) - 3'd1);

	// Build the current word from two answer byte positions
	always_comb begin
		if (job_q.code == JOB_RESYNC) begin
			word = 32'h0;
		end else begin
			word = {answer_half(job_q.code, job_q.report, {idx_q, 1'b1}),
				answer_half(job_q.code, job_q.report, {idx_q, 1'b0})};
		end
	end

	// Load a job and step through its words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= 3'd0;
			end else if (busy_q && adv) begin
				idx_q <= idx_q + 3'd1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				out_valid_q <= busy_q;
			end
		end
	end

	// Hold the job and the output payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (busy_q && adv) begin
			out_kind_q  <= (job_q.code == JOB_RESYNC) ? OUT_RESYNC : OUT_TX;
			tx_word_q   <= word;
			last_word_q <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign tx_word   = tx_word_q;
	assign last_word = last_word_q;

	// A resync result is a single empty word
	a_resync_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == OUT_RESYNC |-> tx_word_q == 32'h0 && last_word_q)
		else $error("resync result not a single empty word");

	// The word index stays inside the answer
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < answer_words(job_q.code))
		else $error("word index beyond answer length");

	// A new job is taken only once the previous one has sent its last word
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !(adv && last) |=> busy_q && $stable(job_q))
		else $error("job replaced before its last word");

endmodule
